// ===== sv/sfrc_pkg.sv =====
// Shared constants and types for the serial frame receiver with checksum.
package sfrc_pkg;

    localparam int BUFFER_LEN = 256;
    localparam int FILL_W     = $clog2(BUFFER_LEN + 1);

    localparam logic [7:0] SYNC_CHAR = 8'h23;  // '#'
    localparam logic [7:0] TERM_CHAR = 8'h0D;  // carriage return
    localparam logic [7:0] CODE_BASE = 8'h3D;  // '='

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic       has_result;
        kind_t      kind;
        logic [7:0] byte_value;
        logic [7:0] position;
        logic [8:0] frame_length;
    } result_t;

endpackage

// ===== sv/sfrc_frame.sv =====
// Frame state (fill count, running sum, last two bytes) and per-byte decision.
module sfrc_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output sfrc_pkg::result_t result
);
    import sfrc_pkg::*;

    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [11:0]       sum_reg, sum_next;
    logic [7:0]        last_reg, last_next;
    logic [7:0]        second_last_reg, second_last_next;

    logic [11:0] check_sum;
    logic [7:0]  hi_char;
    logic [7:0]  lo_char;
    logic [FILL_W-1:0] fill_plus_one;

    // Sum without the two trailing checksum characters, mod 4096 by wrap.
    assign check_sum     = sum_reg - {4'd0, second_last_reg} - {4'd0, last_reg};
    assign hi_char       = CODE_BASE + {2'd0, check_sum[11:6]};
    assign lo_char       = CODE_BASE + {2'd0, check_sum[5:0]};
    assign fill_plus_one = fill_count_reg + FILL_W'(1);

    always_comb
    begin
        fill_count_next  = fill_count_reg;
        sum_next         = sum_reg;
        last_next        = last_reg;
        second_last_next = second_last_reg;
        result           = '0;
        result.kind      = KIND_BYTE;

        if (fill_count_reg == '0)
        begin
            // Hunting: only sync opens a frame.
            if (rx_byte == SYNC_CHAR)
            begin
                result.has_result = 1'b1;
                result.byte_value = rx_byte;
                result.position   = 8'd0;
                sum_next          = {4'd0, rx_byte};
                last_next         = rx_byte;
                second_last_next  = 8'd0;
                fill_count_next   = FILL_W'(1);
            end
        end
        else if (fill_count_reg >= FILL_W'(BUFFER_LEN))
        begin
            // Overrun: drop the byte and go back to hunting.
            fill_count_next = '0;
        end
        else if (rx_byte != TERM_CHAR)
        begin
            result.has_result = 1'b1;
            result.byte_value = rx_byte;
            result.position   = fill_count_reg[7:0];
            sum_next          = sum_reg + {4'd0, rx_byte};
            last_next         = rx_byte;
            second_last_next  = last_reg;
            fill_count_next   = fill_plus_one;
        end
        else
        begin
            result.has_result = 1'b1;
            fill_count_next   = '0;
            if (fill_count_reg >= FILL_W'(3) &&
                hi_char == second_last_reg && lo_char == last_reg)
            begin
                result.kind         = KIND_GOOD;
                result.frame_length = fill_plus_one[8:0];
            end
            else
            begin
                result.kind = KIND_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg  <= '0;
            sum_reg         <= '0;
            last_reg        <= '0;
            second_last_reg <= '0;
        end
        else if (step)
        begin
            fill_count_reg  <= fill_count_next;
            sum_reg         <= sum_next;
            last_reg        <= last_next;
            second_last_reg <= second_last_next;
        end
    end

    // Fill count never passes the buffer length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(BUFFER_LEN))
        else $error("fill count beyond buffer length");

    // A stored byte while hunting is always the sync byte.
    a_open_sync: assert property (@(posedge clk) disable iff (!rst_n)
        step && fill_count_reg == '0 && result.has_result |-> rx_byte == SYNC_CHAR)
        else $error("frame opened without sync");

    // Any result at a terminator returns the block to hunting.
    a_term_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.has_result && result.kind != KIND_BYTE |=> fill_count_reg == '0)
        else $error("frame status without return to hunting");

endmodule

// ===== sv/serial_frame_receiver_checksum.sv =====
// Top level of the serial frame receiver with two-character checksum.
//
// Input channel: rx_byte with in_valid/in_stall; one received byte per
// transfer. Output channel: kind, byte_value, position, frame_length with
// out_valid/out_stall; at most one result transfer per input transfer.
// A frame opens at '#', every stored byte is echoed as kind 0 with its
// position, and a carriage return closes it with kind 1 (checksum good,
// frame_length = stored bytes + 1) or kind 2 (bad or short frame).
// An overrun drops the byte and returns to hunting with no result.
//
// Each result passes through the input register and then the result
// register before it reaches the output.
// Throughput: one byte per cycle while out_stall is low; the frame state
// update is a single 12-bit add and a two-character compare between those
// registers.
// Reset clears the frame state to hunting and empties both registers.
// When the receiver stalls, the result register holds its payload, the
// input register holds the next byte, and in_stall rises once both are
// full; a byte that gives no result still waits for a free result slot.
module serial_frame_receiver_checksum (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] byte_value,
    output logic [7:0] position,
    output logic [8:0] frame_length
);
    import sfrc_pkg::*;

    // Input register
    logic       in_full_reg;
    logic [7:0] in_byte_reg;

    // Result register
    logic       out_valid_reg;
    kind_t      kind_reg;
    logic [7:0] byte_value_reg;
    logic [7:0] position_reg;
    logic [8:0] frame_length_reg;

    result_t result;
    logic    out_free;
    logic    advance;
    logic    in_take;

    // Result slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_full_reg && out_free;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    sfrc_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_valid_reg <= result.has_result;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
        if (advance && result.has_result)
        begin
            kind_reg         <= result.kind;
            byte_value_reg   <= result.byte_value;
            position_reg     <= result.position;
            frame_length_reg <= result.frame_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign byte_value   = byte_value_reg;
    assign position     = position_reg;
    assign frame_length = frame_length_reg;

    // Input only stalls while its register holds an unprocessed byte.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg)
        else $error("input stalled with empty input register");

    // A byte echo carries no frame length.
    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_BYTE |-> frame_length_reg == 9'd0)
        else $error("byte echo with frame length");

    // Frame status carries no byte or position.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_BYTE |->
            byte_value_reg == 8'd0 && position_reg == 8'd0)
        else $error("frame status with byte data");

    // A good frame has sync, two checksum characters and the terminator.
    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_GOOD |-> frame_length_reg >= 9'd4)
        else $error("good frame too short");

endmodule
